### rtl/core/pmo_pkg.sv
// Package for the polyline miter offset block: widths, word types, register
// indexes and the small arithmetic helpers of the data path.
// No dependencies.
`default_nettype none

package pmo_pkg;

  localparam int COORD_W = 48;
  localparam int OFF_W   = 32;
  localparam int HW_W    = 16;
  localparam int SC_W    = 31;
  localparam int CFG_W   = 31;
  localparam int NRM_W   = 32;   // Q2.30 normals and bisectors
  localparam int MA_W    = 33;
  localparam int MB_W    = 32;
  localparam int P_W     = 64;
  localparam int DIV_N   = 40;   // quotient bits per division
  localparam int DIV_W   = 32;
  localparam int SQ_N    = 32;   // root bits per square root

  localparam logic signed [63:0] DOT_LIMIT = 64'sd1118333859468641567;
  localparam logic [63:0] OFF_MAX = (64'd1 << (OFF_W - 1)) - 64'd1;

  typedef enum logic [1:0] {
    CFG_HALF_LEFT  = 2'd0,
    CFG_HALF_RIGHT = 2'd1,
    CFG_SCALE_X    = 2'd2,
    CFG_SCALE_Y    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } vertex_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] left_dx;
    logic signed [OFF_W-1:0] left_dy;
    logic signed [OFF_W-1:0] right_dx;
    logic signed [OFF_W-1:0] right_dy;
    logic                    last_offset;
  } offset_t;

  // Magnitude of a Q2.30 value.
  function automatic logic [NRM_W-1:0] mag_nrm(input logic signed [NRM_W-1:0] v);
    logic [NRM_W-1:0] m;
    m = v[NRM_W-1] ? NRM_W'(-v) : NRM_W'(v);
    return m;
  endfunction

  // Apply a sign to a magnitude and clamp to the offset range.
  function automatic logic signed [OFF_W-1:0] sat_off(input logic neg,
                                                      input logic [63:0] mag);
    logic signed [OFF_W-1:0] r;
    if (!neg) begin
      r = (mag > OFF_MAX) ? OFF_MAX[OFF_W-1:0] : mag[OFF_W-1:0];
    end else if (mag > OFF_MAX + 64'd1) begin
      r = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      r = -$signed(mag[OFF_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/polyline_miter_offset.sv
// Top level of the polyline miter offset block: sequencer, shared multiplier,
// square root and divider. Depends on pmo_pkg.
//
//  channel  | direction | handshake                  | word
//  vertex   | in        | vertex_valid, vertex_stall | vertex_t
//  offset   | out       | offset_valid, offset_stall | offset_t
//  config   | in        | cfg_write                  | cfg_index, cfg_data
//
// After the first vertex a word takes normalising shifts, the 32-step root and
// two passes of the 40-step divider for a plain normal; a bend repeats these for
// the bisector, and a mitred bend adds one more division and root. A final vertex
// adds a second word. No vertex is taken while busy, and the sequencer waits in
// its push state while an output word is stalled. Reset is synchronous and
// restores the register reset values and an empty polyline.
`default_nettype none

module polyline_miter_offset
  import pmo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              vertex_valid,
  output      logic              vertex_stall,
  input  wire vertex_t           vertex,
  output      logic              offset_valid,
  input  wire logic              offset_stall,
  output      offset_t           offset,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int ST_N = 29;

  typedef enum logic [ST_N-1:0] {
    ST_IDLE   = 29'b1 << 0,
    ST_UCHK   = 29'b1 << 1,
    ST_UNORM  = 29'b1 << 2,
    ST_USQA   = 29'b1 << 3,
    ST_USQB   = 29'b1 << 4,
    ST_USQC   = 29'b1 << 5,
    ST_SQRT   = 29'b1 << 6,
    ST_UDVA   = 29'b1 << 7,
    ST_DIV    = 29'b1 << 8,
    ST_UDVB   = 29'b1 << 9,
    ST_UEND   = 29'b1 << 10,
    ST_NSET   = 29'b1 << 11,
    ST_BRANCH = 29'b1 << 12,
    ST_BIS    = 29'b1 << 13,
    ST_DOTA   = 29'b1 << 14,
    ST_DOTB   = 29'b1 << 15,
    ST_TEST   = 29'b1 << 16,
    ST_WIDE   = 29'b1 << 17,
    ST_WMX    = 29'b1 << 18,
    ST_WMY    = 29'b1 << 19,
    ST_WMZ    = 29'b1 << 20,
    ST_EMX    = 29'b1 << 21,
    ST_EMY    = 29'b1 << 22,
    ST_EML1   = 29'b1 << 23,
    ST_EML2   = 29'b1 << 24,
    ST_EMR1   = 29'b1 << 25,
    ST_EMR2   = 29'b1 << 26,
    ST_EMR3   = 29'b1 << 27,
    ST_PUSH   = 29'b1 << 28
  } state_t;

  localparam int DX_W = COORD_W + 1;
  localparam logic [63:0] RND30 = 64'd1 << 29;
  localparam logic [63:0] RND20 = 64'd1 << 19;

  state_t state, ret_unit, ret_sub;
  logic [5:0] cnt;

  logic [HW_W-1:0] left_half, right_half;
  logic [SC_W-1:0] inv_scale_x, inv_scale_y;

  logic signed [COORD_W-1:0] held_x, held_y;
  logic signed [NRM_W-1:0]   prior_nx, prior_ny;
  logic                      have_point, held_is_first, emit_last;

  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic                      cur_last;
  logic signed [NRM_W-1:0]   nx, ny, ux, uy;
  logic [COORD_W-1:0]        ua, ub;
  logic                      usa, usb;
  logic [63:0]               sq_v, sq_r;
  logic [DIV_W-1:0]          div_rem, div_d;
  logic [DIV_N-1:0]          div_q;
  logic [P_W-1:0]            prod;
  logic [MA_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic signed [63:0]        dot;
  logic [31:0]               ox_mag, oy_mag;
  logic                      ox_neg, oy_neg;
  logic [32:0]               tx_mag, ty_mag;
  logic                      tx_neg, ty_neg;
  offset_t                   res;

  logic                      accept, push_ok;
  logic signed [DX_W-1:0]    dx, dy;
  logic                      same_point;
  logic signed [NRM_W:0]     sx, sy;
  logic [COORD_W-1:0]        umax;
  logic [63:0]               sq_bit, sq_t;
  logic                      sq_ge;
  logic [DIV_W:0]            div_t, div_sub;
  logic                      div_ge;
  logic [63:0]               div_dvd, dot_gap, unit_num;
  logic [DIV_W-1:0]          div_den;
  logic signed [63:0]        term;
  logic                      dot_big;
  logic [NRM_W-1:0]          q_nrm;

  assign accept       = vertex_valid && !vertex_stall;
  assign vertex_stall = (state != ST_IDLE);
  assign push_ok      = !offset_valid || !offset_stall;

  assign dx = $signed({vertex.point_x[COORD_W-1], vertex.point_x})
            - $signed({held_x[COORD_W-1], held_x});
  assign dy = $signed({vertex.point_y[COORD_W-1], vertex.point_y})
            - $signed({held_y[COORD_W-1], held_y});
  assign same_point = (vertex.point_x == held_x) && (vertex.point_y == held_y);
  assign sx = $signed({prior_nx[NRM_W-1], prior_nx}) + $signed({nx[NRM_W-1], nx});
  assign sy = $signed({prior_ny[NRM_W-1], prior_ny}) + $signed({ny[NRM_W-1], ny});
  assign umax = (ua > ub) ? ua : ub;

  // One step of the bitwise square root.
  assign sq_bit = 64'd1 << {cnt[4:0], 1'b0};
  assign sq_t   = sq_r + sq_bit;
  assign sq_ge  = (sq_v >= sq_t);

  // One step of the restoring divider.
  assign div_t   = {div_rem, div_q[DIV_N-1]};
  assign div_ge  = (div_t >= {1'b0, div_d});
  assign div_sub = div_t - {1'b0, div_d};

  assign q_nrm   = {1'b0, div_q[NRM_W-2:0]};
  assign term    = (prod[P_W-1:0] == 64'd0) ? 64'sd0 : $signed(prod);
  assign dot_big = (dot >= DOT_LIMIT) || (dot <= -DOT_LIMIT);
  assign dot_gap = (64'd1 << 60) - 64'(dot);
  assign unit_num = (state == ST_UDVA) ? 64'(ua[30:0]) : 64'(ub[30:0]);

  always_comb begin
    div_dvd = '0;
    div_den = '0;
    unique case (state)
      ST_UDVA, ST_UDVB: begin
        div_dvd = (unit_num << 30) + (sq_r >> 1);
        div_den = sq_r[DIV_W-1:0];
      end
      ST_TEST: begin
        div_dvd = 64'd1 << 61;
        div_den = dot_gap[61:30];
      end
      default: begin
        div_dvd = '0;
        div_den = '0;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_USQA: begin mul_a = ua[MA_W-1:0]; mul_b = ua[MB_W-1:0]; end
      ST_USQB: begin mul_a = ub[MA_W-1:0]; mul_b = ub[MB_W-1:0]; end
      ST_BIS:  begin mul_a = MA_W'(mag_nrm(prior_nx)); mul_b = mag_nrm(nx); end
      ST_DOTA: begin mul_a = MA_W'(mag_nrm(prior_ny)); mul_b = mag_nrm(ny); end
      ST_WMX:  begin mul_a = MA_W'(mag_nrm(ux)); mul_b = sq_r[MB_W-1:0]; end
      ST_WMY:  begin mul_a = MA_W'(mag_nrm(uy)); mul_b = sq_r[MB_W-1:0]; end
      ST_EMX:  begin mul_a = MA_W'(ox_mag); mul_b = MB_W'(inv_scale_x); end
      ST_EMY:  begin mul_a = MA_W'(oy_mag); mul_b = MB_W'(inv_scale_y); end
      ST_EML1: begin mul_a = tx_mag; mul_b = MB_W'(left_half); end
      ST_EML2: begin mul_a = ty_mag; mul_b = MB_W'(left_half); end
      ST_EMR1: begin mul_a = tx_mag; mul_b = MB_W'(right_half); end
      ST_EMR2: begin mul_a = ty_mag; mul_b = MB_W'(right_half); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Control: sequencer, configuration, polyline state and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ret_unit         <= ST_IDLE;
      ret_sub          <= ST_IDLE;
      cnt              <= '0;
      offset_valid     <= 1'b0;
      left_half        <= '0;
      right_half       <= '0;
      inv_scale_x      <= SC_W'(1) << 30;
      inv_scale_y      <= SC_W'(1) << 30;
      held_x           <= '0;
      held_y           <= '0;
      prior_nx         <= '0;
      prior_ny         <= '0;
      have_point       <= 1'b0;
      held_is_first    <= 1'b1;
      emit_last        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_HALF_LEFT:  left_half   <= cfg_data[HW_W-1:0];
          CFG_HALF_RIGHT: right_half  <= cfg_data[HW_W-1:0];
          CFG_SCALE_X:    inv_scale_x <= cfg_data[SC_W-1:0];
          CFG_SCALE_Y:    inv_scale_y <= cfg_data[SC_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_PUSH && push_ok) begin
        offset_valid <= 1'b1;
      end else if (!offset_stall) begin
        offset_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!have_point) begin
              if (vertex.last_point) begin
                emit_last <= 1'b1;
                state     <= ST_EMX;
              end else begin
                held_x        <= vertex.point_x;
                held_y        <= vertex.point_y;
                prior_nx      <= '0;
                prior_ny      <= '0;
                have_point    <= 1'b1;
                held_is_first <= 1'b1;
              end
            end else if (same_point) begin
              state <= ST_BRANCH;
            end else begin
              ret_unit <= ST_NSET;
              state    <= ST_UCHK;
            end
          end
        end
        ST_UCHK:  state <= (ua == '0 && ub == '0) ? ret_unit : ST_UNORM;
        ST_UNORM: begin
          if (umax[COORD_W-1:31] == '0 && umax[30]) begin
            state <= ST_USQA;
          end
        end
        ST_USQA: state <= ST_USQB;
        ST_USQB: state <= ST_USQC;
        ST_USQC: begin
          cnt     <= 6'(SQ_N - 1);
          ret_sub <= ST_UDVA;
          state   <= ST_SQRT;
        end
        ST_SQRT, ST_DIV: begin
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= ret_sub;
          end
        end
        ST_UDVA: begin
          cnt     <= 6'(DIV_N - 1);
          ret_sub <= ST_UDVB;
          state   <= ST_DIV;
        end
        ST_UDVB: begin
          cnt     <= 6'(DIV_N - 1);
          ret_sub <= ST_UEND;
          state   <= ST_DIV;
        end
        ST_UEND: state <= ret_unit;
        ST_NSET: state <= ST_BRANCH;
        ST_BRANCH: begin
          if (held_is_first) begin
            state <= ST_EMX;
          end else begin
            ret_unit <= ST_BIS;
            state    <= ST_UCHK;
          end
        end
        ST_BIS:  state <= (ux == '0 && uy == '0) ? ST_EMX : ST_DOTA;
        ST_DOTA: state <= ST_DOTB;
        ST_DOTB: state <= ST_TEST;
        ST_TEST: begin
          if (dot_big) begin
            state <= ST_EMX;
          end else begin
            cnt     <= 6'(DIV_N - 1);
            ret_sub <= ST_WIDE;
            state   <= ST_DIV;
          end
        end
        ST_WIDE: begin
          cnt     <= 6'(SQ_N - 1);
          ret_sub <= ST_WMX;
          state   <= ST_SQRT;
        end
        ST_WMX:  state <= ST_WMY;
        ST_WMY:  state <= ST_WMZ;
        ST_WMZ:  state <= ST_EMX;
        ST_EMX:  state <= ST_EMY;
        ST_EMY:  state <= ST_EML1;
        ST_EML1: state <= ST_EML2;
        ST_EML2: state <= ST_EMR1;
        ST_EMR1: state <= ST_EMR2;
        ST_EMR2: state <= ST_EMR3;
        ST_EMR3: state <= ST_PUSH;
        ST_PUSH: begin
          if (push_ok) begin
            if (emit_last) begin
              // The polyline is complete: start afresh.
              held_x        <= '0;
              held_y        <= '0;
              prior_nx      <= '0;
              prior_ny      <= '0;
              have_point    <= 1'b0;
              held_is_first <= 1'b1;
              emit_last     <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              prior_nx      <= nx;
              prior_ny      <= ny;
              held_x        <= cur_x;
              held_y        <= cur_y;
              held_is_first <= 1'b0;
              if (cur_last) begin
                emit_last <= 1'b1;
                state     <= ST_EMX;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    prod <= P_W'(mul_a) * P_W'(mul_b);
    unique case (state)
      ST_IDLE: begin
        cur_x    <= vertex.point_x;
        cur_y    <= vertex.point_y;
        cur_last <= vertex.last_point;
        nx       <= prior_nx;
        ny       <= prior_ny;
        ox_mag   <= '0;
        oy_mag   <= '0;
        ox_neg   <= 1'b0;
        oy_neg   <= 1'b0;
        ua  <= dy[DX_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
        usa <= !dy[DX_W-1];
        ub  <= dx[DX_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        usb <= dx[DX_W-1];
      end
      ST_UCHK: begin
        ux <= '0;
        uy <= '0;
      end
      ST_UNORM: begin
        if (umax[COORD_W-1:31] != '0) begin
          ua <= ua >> 1;
          ub <= ub >> 1;
        end else if (!umax[30]) begin
          ua <= ua << 1;
          ub <= ub << 1;
        end
      end
      ST_USQB: sq_v <= prod;
      ST_USQC: begin
        sq_v <= sq_v + prod;
        sq_r <= '0;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end
      ST_UDVA, ST_UDVB, ST_TEST: begin
        div_rem <= DIV_W'(div_dvd[63:DIV_N]);
        div_q   <= div_dvd[DIV_N-1:0];
        div_d   <= div_den;
        if (state == ST_UDVB) begin
          ux <= usa ? -$signed(q_nrm) : $signed(q_nrm);
        end
        if (state == ST_TEST) begin
          ox_mag <= 32'(({1'b0, mag_nrm(ux)} + 33'd2) >> 2);
          oy_mag <= 32'(({1'b0, mag_nrm(uy)} + 33'd2) >> 2);
          ox_neg <= ux[NRM_W-1];
          oy_neg <= uy[NRM_W-1];
        end
      end
      ST_DIV: begin
        div_rem <= div_ge ? div_sub[DIV_W-1:0] : div_t[DIV_W-1:0];
        div_q   <= {div_q[DIV_N-2:0], div_ge};
      end
      ST_UEND: uy <= usb ? -$signed(q_nrm) : $signed(q_nrm);
      ST_NSET: begin
        nx <= ux;
        ny <= uy;
      end
      ST_BRANCH: begin
        ox_mag <= 32'(({1'b0, mag_nrm(nx)} + 33'd2) >> 2);
        oy_mag <= 32'(({1'b0, mag_nrm(ny)} + 33'd2) >> 2);
        ox_neg <= nx[NRM_W-1];
        oy_neg <= ny[NRM_W-1];
        ua  <= sx[NRM_W] ? COORD_W'(-sx) : COORD_W'(sx);
        usa <= sx[NRM_W];
        ub  <= sy[NRM_W] ? COORD_W'(-sy) : COORD_W'(sy);
        usb <= sy[NRM_W];
      end
      ST_BIS: begin
        ox_mag <= '0;
        oy_mag <= '0;
      end
      // The dot product is negated: it compares the previous normal with
      // the reversed current one.
      ST_DOTA: dot <= (prior_nx[NRM_W-1] ^ nx[NRM_W-1]) ? term : -term;
      ST_DOTB: dot <= (prior_ny[NRM_W-1] ^ ny[NRM_W-1]) ? dot + term : dot - term;
      ST_WIDE: begin
        sq_v <= 64'(div_q[36:0]) << 26;
        sq_r <= '0;
      end
      ST_WMY: begin
        ox_mag <= 32'((prod + RND30) >> 30);
        ox_neg <= ux[NRM_W-1];
      end
      ST_WMZ: begin
        oy_mag <= 32'((prod + RND30) >> 30);
        oy_neg <= uy[NRM_W-1];
      end
      ST_EMY: begin
        tx_mag <= 33'((prod + RND30) >> 30);
        tx_neg <= ox_neg;
      end
      ST_EML1: begin
        ty_mag <= 33'((prod + RND30) >> 30);
        ty_neg <= oy_neg;
      end
      ST_EML2: res.left_dx  <= sat_off(!tx_neg, (prod + RND20) >> 20);
      ST_EMR1: res.left_dy  <= sat_off(!ty_neg, (prod + RND20) >> 20);
      ST_EMR2: res.right_dx <= sat_off(tx_neg, (prod + RND20) >> 20);
      ST_EMR3: res.right_dy <= sat_off(ty_neg, (prod + RND20) >> 20);
      ST_PUSH: begin
        if (push_ok) begin
          offset <= '{left_dx: res.left_dx, left_dy: res.left_dy,
                      right_dx: res.right_dx, right_dy: res.right_dy,
                      last_offset: emit_last};
          // The final vertex uses the last segment's normal unchanged.
          ox_mag <= 32'(({1'b0, mag_nrm(nx)} + 33'd2) >> 2);
          oy_mag <= 32'(({1'b0, mag_nrm(ny)} + 33'd2) >> 2);
          ox_neg <= nx[NRM_W-1];
          oy_neg <= ny[NRM_W-1];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_rem < div_d))
    else $error("divider remainder not below divisor");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_USQA) |-> ((ua >> 31) == '0 && (ub >> 31) == '0 && (ua[30] || ub[30])))
    else $error("vector not normalised before squaring");

  a_first: assert property (@(posedge clk) disable iff (rst)
    !held_is_first |-> have_point)
    else $error("inner vertex state without a held vertex");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && push_ok && emit_last) |=>
      (!have_point && held_is_first && state == ST_IDLE))
    else $error("polyline state not cleared after final word");
`endif

endmodule

`default_nettype wire

### tb/tb_polyline_miter_offset.sv
// Self-checking testbench for polyline_miter_offset: polylines go in, and the
// edge offsets that come out are compared with a fixed-point predictor.
// Depends on pmo_pkg and the polyline_miter_offset RTL.
`timescale 1ns / 1ps

module tb_polyline_miter_offset;
  import pmo_pkg::*;

  localparam int  DRAIN_CYCLES = 400;
  localparam int  HANG_LIMIT   = 20000;
  localparam longint COORD_MAX = (64'sd1 <<< 47) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< 47);

  logic             clk;
  logic             rst;
  logic             vertex_valid;
  logic             vertex_stall;
  vertex_t          vertex;
  logic             offset_valid;
  logic             offset_stall;
  offset_t          offset;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  polyline_miter_offset dut (
    .clk(clk), .rst(rst),
    .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
    .offset_valid(offset_valid), .offset_stall(offset_stall), .offset(offset),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the polyline state.
  bit [63:0] half_left, half_right, scale_x, scale_y;
  longint    held_x, held_y, prev_nx, prev_ny;
  bit        have_vertex, held_first;

  offset_t pending_offsets[$];
  int      errors = 0;
  bit      quiet;
  int      stall_free_cycles = 0;

  function automatic bit [63:0] isqrt(input bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Signed value times unsigned factor, shifted right with rounding away from zero.
  function automatic longint scale_round(input longint a, input bit [63:0] b, input int sh);
    bit [63:0] m;
    bit [63:0] p;
    m = (a < 0) ? 64'(-a) : 64'(a);
    p = (m * b + (64'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void unit_q30(input bit [63:0] ma, input bit na, input bit [63:0] mb,
                                   input bit nb, output longint ux, output longint uy);
    bit [63:0] mx;
    bit [63:0] len;
    bit [63:0] qa;
    bit [63:0] qb;
    if (ma == 0 && mb == 0) begin
      ux = 0;
      uy = 0;
      return;
    end
    mx = (ma > mb) ? ma : mb;
    while (mx >= (64'd1 << 31)) begin
      ma >>= 1; mb >>= 1; mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      ma <<= 1; mb <<= 1; mx <<= 1;
    end
    len = isqrt(ma * ma + mb * mb);
    qa = ((ma << 30) + len / 2) / len;
    qb = ((mb << 30) + len / 2) / len;
    ux = na ? -longint'(qa) : longint'(qa);
    uy = nb ? -longint'(qb) : longint'(qb);
  endfunction

  // Mitred offset at an inner vertex, Q28.
  function automatic void miter_q28(input longint px, input longint py, input longint nx,
                                    input longint ny, output longint ox, output longint oy);
    longint    sx, sy, bx, by, dot;
    bit [63:0] r, recip, wide;
    sx = px + nx;
    sy = py + ny;
    unit_q30((sx < 0) ? 64'(-sx) : 64'(sx), sx < 0, (sy < 0) ? 64'(-sy) : 64'(sy), sy < 0,
             bx, by);
    if (bx == 0 && by == 0) begin
      ox = 0;
      oy = 0;
      return;
    end
    dot = -(px * nx + py * ny);
    if (dot >= DOT_LIMIT || dot <= -DOT_LIMIT) begin
      ox = scale_round(bx, 1, 2);
      oy = scale_round(by, 1, 2);
      return;
    end
    r = ((64'd1 << 60) - 64'(dot)) >> 30;
    recip = (64'd1 << 61) / r;
    wide = isqrt(recip << 26);
    ox = scale_round(bx, wide, 30);
    oy = scale_round(by, wide, 30);
  endfunction

  function automatic logic signed [OFF_W-1:0] clamp_off(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[OFF_W-1:0];
  endfunction

  function automatic offset_t edge_offsets(input longint ox, input longint oy, input bit fin);
    offset_t o;
    longint  tx, ty;
    tx = scale_round(ox, scale_x, 30);
    ty = scale_round(oy, scale_y, 30);
    o.left_dx     = clamp_off(-scale_round(tx, half_left, 20));
    o.left_dy     = clamp_off(-scale_round(ty, half_left, 20));
    o.right_dx    = clamp_off(scale_round(tx, half_right, 20));
    o.right_dy    = clamp_off(scale_round(ty, half_right, 20));
    o.last_offset = fin;
    return o;
  endfunction

  function automatic void clear_polyline();
    held_x = 0; held_y = 0; prev_nx = 0; prev_ny = 0;
    have_vertex = 0; held_first = 1;
  endfunction

  function automatic void predict_offsets(input vertex_t v);
    longint    x, y, nx, ny, ox, oy;
    bit [63:0] mx, my;
    bit        negx, negy;
    x = longint'($signed(v.point_x));
    y = longint'($signed(v.point_y));
    if (!have_vertex) begin
      clear_polyline();
      if (v.last_point) begin
        pending_offsets.push_back(edge_offsets(0, 0, 1));
      end else begin
        held_x = x; held_y = y; have_vertex = 1;
      end
      return;
    end
    if (x == held_x && y == held_y) begin
      // A repeated vertex keeps the normal of the previous segment.
      nx = prev_nx; ny = prev_ny;
    end else begin
      negx = x < held_x;
      negy = y < held_y;
      mx = negx ? 64'(held_x - x) : 64'(x - held_x);
      my = negy ? 64'(held_y - y) : 64'(y - held_y);
      unit_q30(my, !negy, mx, negx, nx, ny);
    end
    if (held_first) begin
      ox = scale_round(nx, 1, 2);
      oy = scale_round(ny, 1, 2);
    end else begin
      miter_q28(prev_nx, prev_ny, nx, ny, ox, oy);
    end
    pending_offsets.push_back(edge_offsets(ox, oy, 0));
    prev_nx = nx; prev_ny = ny;
    held_x = x; held_y = y;
    held_first = 0;
    if (v.last_point) begin
      pending_offsets.push_back(edge_offsets(scale_round(nx, 1, 2), scale_round(ny, 1, 2), 1));
      clear_polyline();
    end
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls in random bursts.
  initial begin
    offset_stall = 0;
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        offset_stall <= 1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        offset_stall <= 0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    offset_t want;
    if (!rst && offset_valid && !offset_stall) begin
      if (pending_offsets.size() == 0) begin
        $display("%0t: unexpected offset word, expected none, actual %h", $time, offset);
        errors++;
      end else begin
        want = pending_offsets.pop_front();
        if (offset.left_dx !== want.left_dx)
          $display("%0t: left_dx expected %0d actual %0d", $time, want.left_dx, offset.left_dx);
        if (offset.left_dy !== want.left_dy)
          $display("%0t: left_dy expected %0d actual %0d", $time, want.left_dy, offset.left_dy);
        if (offset.right_dx !== want.right_dx)
          $display("%0t: right_dx expected %0d actual %0d", $time, want.right_dx,
                   offset.right_dx);
        if (offset.right_dy !== want.right_dy)
          $display("%0t: right_dy expected %0d actual %0d", $time, want.right_dy,
                   offset.right_dy);
        if (offset.last_offset !== want.last_offset)
          $display("%0t: last_offset expected %0b actual %0b", $time, want.last_offset,
                   offset.last_offset);
        if (offset !== want) errors++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((vertex_valid && !vertex_stall) || (offset_valid && !offset_stall))
      stall_free_cycles <= 0;
    else
      stall_free_cycles <= stall_free_cycles + 1;
    if (stall_free_cycles > HANG_LIMIT) begin
      $display("[polyline_miter_offset] ERROR");
      $finish;
    end
  end

  // Leaves valid high on return unless an idle burst was taken; the caller
  // either sends again at once or lowers valid.
  task automatic send_vertex(input longint x, input longint y, input bit fin);
    vertex_t v;
    v.point_x = x[COORD_W-1:0];
    v.point_y = y[COORD_W-1:0];
    v.last_point = fin;
    vertex <= v;
    vertex_valid <= 1;
    do @(posedge clk); while (vertex_stall);
    predict_offsets(v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      vertex_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    vertex_valid <= 0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input cfg_index_t idx, input bit [CFG_W-1:0] data);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_HALF_LEFT:  half_left  = data[HW_W-1:0];
      CFG_HALF_RIGHT: half_right = data[HW_W-1:0];
      CFG_SCALE_X:    scale_x    = data[SC_W-1:0];
      CFG_SCALE_Y:    scale_y    = data[SC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input bit [15:0] hl, input bit [15:0] hr, input bit [30:0] sx,
                          input bit [30:0] sy);
    drain();
    write_reg(CFG_HALF_LEFT, CFG_W'(hl));
    write_reg(CFG_HALF_RIGHT, CFG_W'(hr));
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    cfg_write <= 0;
  endtask

  task automatic test_single_vertex();
    send_vertex(5, 7, 1);
    send_vertex(-3, 0, 1);
  endtask

  task automatic test_turns();
    // Straight run ending in a right-angle turn.
    send_vertex(0, 0, 0);
    send_vertex(1 << 16, 0, 0);
    send_vertex(2 << 16, 0, 0);
    send_vertex(2 << 16, 3 << 16, 1);
    // Doubling back on itself leaves no bisector.
    send_vertex(0, 0, 0);
    send_vertex(1 << 16, 0, 0);
    send_vertex(0, 0, 1);
    // A shallow bend is not widened.
    send_vertex(0, 0, 0);
    send_vertex(100 << 16, 0, 0);
    send_vertex(200 << 16, 1 << 16, 1);
    // A very sharp bend is not widened either.
    send_vertex(0, 0, 0);
    send_vertex(10 << 16, 0, 0);
    send_vertex(0, 1 << 16, 1);
  endtask

  task automatic test_duplicates();
    send_vertex(3, 3, 0);
    send_vertex(3, 3, 0);
    send_vertex(9, 3, 0);
    send_vertex(9, 3, 0);
    send_vertex(9, 10, 1);
  endtask

  task automatic test_extremes();
    send_vertex(COORD_MAX, COORD_MAX, 0);
    send_vertex(COORD_MIN, COORD_MIN, 0);
    send_vertex(COORD_MAX, COORD_MIN, 1);
  endtask

  function automatic longint random_coord();
    return longint'($signed({$urandom, $urandom}) >>> 16);
  endfunction

  function automatic longint random_step(input longint from);
    longint d;
    d = longint'($signed($urandom)) >>> $urandom_range(0, 31);
    return from + (d <<< $urandom_range(0, 15));
  endfunction

  task automatic test_random_polylines(input int count);
    int     sent;
    int     len;
    longint x, y;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) begin
        x = random_coord(); y = random_coord();
      end else begin
        x = longint'($signed($urandom)) >>> 2;
        y = longint'($signed($urandom)) >>> 2;
      end
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0: ;
          1: begin
            x = random_coord(); y = random_coord();
          end
          2: x = random_step(x);
          3: y = random_step(y);
          default: begin
            x = random_step(x); y = random_step(y);
          end
        endcase
        send_vertex(x, y, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    quiet = 0;
    rst = 1;
    vertex_valid = 0;
    vertex = '0;
    cfg_write = 0;
    cfg_index = CFG_HALF_LEFT;
    cfg_data = '0;
    half_left = 0;
    half_right = 0;
    scale_x = 64'd1 << 30;
    scale_y = 64'd1 << 30;
    clear_polyline();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_single_vertex();
    set_regs(16'h0180, 16'h0240, 31'h40000000, 31'h40000000);
    test_single_vertex();
    test_turns();
    test_duplicates();
    set_regs(16'hffff, 16'hffff, 31'h7fffffff, 31'h0);
    test_extremes();
    test_turns();
    set_regs(16'($urandom), 16'($urandom), 31'($urandom), 31'($urandom));
    test_random_polylines(120);
    set_regs(16'h0000, 16'hffff, 31'h0, 31'h7fffffff);
    test_random_polylines(80);
    set_regs(16'($urandom), 16'($urandom), 31'($urandom_range(31'h20000000, 31'h60000000)),
             31'($urandom_range(31'h20000000, 31'h60000000)));
    test_random_polylines(120);
    drain();
    quiet = 1;
    test_random_polylines(80);
    drain();

    if (errors == 0)
      $display("[polyline_miter_offset] OK");
    else
      $display("[polyline_miter_offset] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/pmo_pkg.sv
rtl/core/polyline_miter_offset.sv
tb/tb_polyline_miter_offset.sv
